FILE: sv/scba_pkg.sv
package scba_pkg;

   localparam int SIZE_W    = 17;
   localparam int IDX_W     = 4;
   localparam int CLS_RAW_W = 5;
   localparam int CLS_OUT_W = 4;
   localparam int STATUS_W  = 2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE = 2'd3;

   // One classified request as it waits between the front and the back.
   typedef struct packed {
      logic                 func;
      logic                 too_large;
      logic [CLS_RAW_W-1:0] cls;
      logic [IDX_W-1:0]     idx;
   } scba_req_type;

   typedef struct packed {
      logic         valid;
      scba_req_type req;
   } scba_queue_type;

   typedef struct packed {
      logic take;
      logic clearing;
   } scba_back_ctl_type;

endpackage

FILE: sv/scba_front.sv
module scba_front import scba_pkg::*; #(
   parameter int NUM_CLASSES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_func,
   input  logic [SIZE_W-1:0]    req_request_size,
   input  logic [IDX_W-1:0]     req_block_index,
   output scba_queue_type       queue_out,
   input  scba_back_ctl_type    back_ctl
);

   localparam int QDEPTH = 2;

   // Class is the bit length of n-1, minus one; sizes of zero and one go to class zero.
   function automatic logic [CLS_RAW_W-1:0] class_of(input logic [SIZE_W-1:0] n);
      logic [SIZE_W-1:0]    v;
      logic [CLS_RAW_W-1:0] len;
      v   = n - SIZE_W'(1);
      len = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (v[i]) begin
            len = CLS_RAW_W'(i + 1);
         end
      end
      if (n <= SIZE_W'(1)) begin
         class_of = '0;
      end else begin
         class_of = len - CLS_RAW_W'(1);
      end
   endfunction

   scba_req_type entry_ff [QDEPTH];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   scba_req_type new_req;
   logic         accept;

   always_comb begin
      new_req.func      = req_func;
      new_req.cls       = class_of(req_request_size);
      new_req.too_large = (int'(new_req.cls) >= NUM_CLASSES);
      new_req.idx       = req_block_index;
   end

   assign req_full = (count_ff == 2'(QDEPTH)) | back_ctl.clearing;
   assign accept   = req_push & ~req_full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (back_ctl.take) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (accept & ~back_ctl.take) begin
         count_in = count_ff + 2'd1;
      end else if (~accept & back_ctl.take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= new_req;
      end
   end

   assign queue_out.valid = (count_ff != 2'd0);
   assign queue_out.req   = entry_ff[rd_ptr_ff];

endmodule

FILE: sv/scba_back.sv
module scba_back import scba_pkg::*; #(
   parameter int NUM_CLASSES      = 16,
   parameter int BLOCKS_PER_CLASS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scba_queue_type        queue_in,
   output scba_back_ctl_type     back_ctl,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [CLS_OUT_W-1:0]  rsp_size_class,
   output logic [IDX_W-1:0]      rsp_granted_block
);

   localparam int TOTAL = NUM_CLASSES * BLOCKS_PER_CLASS;
   localparam int AW    = $clog2(TOTAL);
   localparam int LW    = $clog2(BLOCKS_PER_CLASS + 1);
   localparam int BW    = $clog2(BLOCKS_PER_CLASS);
   localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   // Memory word: bit LW is the in-use mark, the rest is the link to the next free block.
   logic [LW:0]          link_mem [TOTAL];
   logic [LW:0]          rd_ff;

   logic [LW-1:0]        head_ff [NUM_CLASSES];
   logic [1:0]           state_ff, state_in;
   logic [AW-1:0]        clr_slot_ff, clr_slot_in;
   logic [BW-1:0]        clr_blk_ff, clr_blk_in;

   scba_req_type         op_ff;
   logic [CW-1:0]        cls_ff;
   logic [BW-1:0]        blk_ff;
   logic [AW-1:0]        addr_ff;
   logic [STATUS_W-1:0]  pre_status_ff;

   logic                 out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]  out_status_ff;
   logic [CLS_OUT_W-1:0] out_class_ff;
   logic [IDX_W-1:0]     out_granted_ff;

   logic [CW-1:0]        cls_sel;
   logic [LW-1:0]        head_sel;
   logic                 idx_ok;
   logic                 exhausted;
   logic [BW-1:0]        blk_sel;
   logic [AW-1:0]        addr_sel;
   logic [STATUS_W-1:0]  pre_status;
   logic                 take;
   logic                 exec;

   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [LW:0]          mem_wd;
   logic                 head_we;
   logic [LW-1:0]        head_wd;
   logic [STATUS_W-1:0]  fin_status;
   logic [IDX_W-1:0]     fin_granted;

   // Look up the class head and form the memory address for the request at the queue head.
   always_comb begin
      cls_sel   = queue_in.req.too_large ? '0 : queue_in.req.cls[CW-1:0];
      head_sel  = head_ff[cls_sel];
      exhausted = (head_sel >= LW'(BLOCKS_PER_CLASS));
      idx_ok    = (int'(queue_in.req.idx) < BLOCKS_PER_CLASS);
      blk_sel   = '0;
      if (queue_in.req.func == FUNC_ALLOC) begin
         if (!exhausted) begin
            blk_sel = BW'(head_sel);
         end
      end else if (idx_ok) begin
         blk_sel = BW'(queue_in.req.idx);
      end
      addr_sel = AW'(cls_sel) * AW'(BLOCKS_PER_CLASS) + AW'(blk_sel);
      if (queue_in.req.too_large) begin
         pre_status = STATUS_TOO_LARGE;
      end else if (queue_in.req.func == FUNC_ALLOC) begin
         pre_status = exhausted ? STATUS_EXHAUSTED : STATUS_OK;
      end else begin
         pre_status = idx_ok ? STATUS_OK : STATUS_NOT_IN_USE;
      end
   end

   assign take = (state_ff == ST_READ) & queue_in.valid & (~out_valid_ff | rsp_pop);
   assign exec = (state_ff == ST_EXEC);

   always_comb begin
      state_in    = state_ff;
      clr_slot_in = clr_slot_ff;
      clr_blk_in  = clr_blk_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_slot_in = clr_slot_ff + AW'(1);
            if (clr_blk_ff == BW'(BLOCKS_PER_CLASS - 1)) begin
               clr_blk_in = '0;
            end else begin
               clr_blk_in = clr_blk_ff + BW'(1);
            end
            if (clr_slot_ff == AW'(TOTAL - 1)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_READ;
         end
         default: begin
            state_in = ST_READ;
         end
      endcase
   end

   // Clearing-pass write of each block's first link, else read-modify-write of the addressed block and the class head.
   always_comb begin
      mem_we      = 1'b0;
      mem_wa      = addr_ff;
      mem_wd      = rd_ff;
      head_we     = 1'b0;
      head_wd     = rd_ff[LW-1:0];
      fin_status  = pre_status_ff;
      fin_granted = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_slot_ff;
         mem_wd = {1'b0, LW'(clr_blk_ff) + LW'(1)};
      end else if (exec && pre_status_ff == STATUS_OK) begin
         if (op_ff.func == FUNC_ALLOC) begin
            mem_we      = 1'b1;
            mem_wd      = {1'b1, rd_ff[LW-1:0]};
            head_we     = 1'b1;
            head_wd     = rd_ff[LW-1:0];
            fin_granted = IDX_W'(blk_ff);
         end else if (!rd_ff[LW]) begin
            fin_status = STATUS_NOT_IN_USE;
         end else begin
            mem_we  = 1'b1;
            mem_wd  = {1'b0, head_ff[cls_ff]};
            head_we = 1'b1;
            head_wd = LW'(blk_ff);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_pop;
      if (exec) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_slot_ff  <= '0;
         clr_blk_ff   <= '0;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_slot_ff  <= clr_slot_in;
         clr_blk_ff   <= clr_blk_in;
         out_valid_ff <= out_valid_in;
         if (head_we) begin
            head_ff[cls_ff] <= head_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff         <= queue_in.req;
         cls_ff        <= cls_sel;
         blk_ff        <= blk_sel;
         addr_ff       <= addr_sel;
         pre_status_ff <= pre_status;
      end
      if (exec) begin
         out_status_ff  <= fin_status;
         out_class_ff   <= op_ff.too_large ? '0 : op_ff.cls[CLS_OUT_W-1:0];
         out_granted_ff <= fin_granted;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= link_mem[addr_sel];
   end

   assign back_ctl.take     = take;
   assign back_ctl.clearing = (state_ff == ST_CLEAR);

   assign rsp_empty         = ~out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_size_class    = out_class_ff;
   assign rsp_granted_block = out_granted_ff;

endmodule

FILE: sv/size_class_block_allocator_top.sv
// Power-of-two size-class block allocator, seen as a queue on both sides.
// Requests: drive req_func, req_request_size and req_block_index with req_push; a request
// is taken at a clock edge where req_push is high and req_full is low. The front classifies
// the size and holds up to two requests; the back carries them out against the free lists.
// Responses: while rsp_empty is low, rsp_status, rsp_size_class and rsp_granted_block show
// the oldest response; it is taken at an edge where rsp_pop is high.
// Path: a request taken into an empty block passes the front's entry register, then the back's
// read state and its write state, before its response shows.
// Pacing: the back takes no new request until it has finished the last one, because of the
// read-modify-write of the link memory and the class head for each request.
// Reset: the free-list heads clear at once; then a clearing pass rebuilds the link memory
// for all NUM_CLASSES * BLOCKS_PER_CLASS blocks, one block a cycle, and req_full stays high
// until it ends.
// Stall: while the response waits to be popped the back holds; the front keeps taking
// requests until its two entries are full, then raises req_full.
module size_class_block_allocator_top import scba_pkg::*; #(
   parameter int NUM_CLASSES      = 16,
   parameter int BLOCKS_PER_CLASS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_func,
   input  logic [SIZE_W-1:0]     req_request_size,
   input  logic [IDX_W-1:0]      req_block_index,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [CLS_OUT_W-1:0]  rsp_size_class,
   output logic [IDX_W-1:0]      rsp_granted_block
);

   scba_queue_type    queue;
   scba_back_ctl_type back_ctl;

   scba_front #(
      .NUM_CLASSES(NUM_CLASSES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_request_size (req_request_size),
      .req_block_index  (req_block_index),
      .queue_out        (queue),
      .back_ctl         (back_ctl)
   );

   scba_back #(
      .NUM_CLASSES      (NUM_CLASSES),
      .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_in          (queue),
      .back_ctl          (back_ctl),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_size_class    (rsp_size_class),
      .rsp_granted_block (rsp_granted_block)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench import scba_pkg::*;;

   localparam int NUM_CLASSES      = 16;
   localparam int BLOCKS_PER_CLASS = 16;
   localparam int TOTAL_BLOCKS     = NUM_CLASSES * BLOCKS_PER_CLASS;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [CLS_OUT_W-1:0] size_class;
      logic [IDX_W-1:0]     granted_block;
   } alloc_response_type;

   // Tracks the free lists and the in-use marks, and holds the responses still owed.
   class free_list_scoreboard;
      logic [IDX_W:0]     list_head [NUM_CLASSES];
      logic [IDX_W:0]     next_free [TOTAL_BLOCKS];
      bit                 claimed [TOTAL_BLOCKS];
      alloc_response_type awaited_responses [$];
      int                 errors;

      function new();
         int c;
         int b;
         errors = 0;
         for (c = 0; c < NUM_CLASSES; c++) begin
            list_head[c] = '0;
            for (b = 0; b < BLOCKS_PER_CLASS; b++) begin
               next_free[c * BLOCKS_PER_CLASS + b] = (IDX_W + 1)'(b + 1);
               claimed[c * BLOCKS_PER_CLASS + b] = 1'b0;
            end
         end
      endfunction

      // The class is the index of the top set bit of n-1.
      function int size_to_class(logic [SIZE_W-1:0] n);
         logic [SIZE_W-1:0] v;
         int                top;
         int                i;
         top = 0;
         if (n <= 1) return 0;
         v = n - 1;
         for (i = 0; i < SIZE_W; i++) begin
            if (v[i]) top = i;
         end
         return top;
      endfunction

      function void note_request(logic f, logic [SIZE_W-1:0] size, logic [IDX_W-1:0] idx);
         alloc_response_type want;
         int                 c;
         int                 slot;
         logic [IDX_W:0]     head;
         want.status = STATUS_OK;
         want.granted_block = '0;
         c = size_to_class(size);
         if (c >= NUM_CLASSES) begin
            want.status = STATUS_TOO_LARGE;
            c = 0;
         end else if (f == FUNC_ALLOC) begin
            head = list_head[c];
            if (head >= BLOCKS_PER_CLASS) begin
               want.status = STATUS_EXHAUSTED;
            end else begin
               slot = c * BLOCKS_PER_CLASS + head;
               claimed[slot] = 1'b1;
               list_head[c] = next_free[slot];
               want.granted_block = head[IDX_W-1:0];
            end
         end else begin
            slot = c * BLOCKS_PER_CLASS + idx;
            if (idx >= BLOCKS_PER_CLASS || !claimed[slot]) begin
               want.status = STATUS_NOT_IN_USE;
            end else begin
               claimed[slot] = 1'b0;
               next_free[slot] = list_head[c];
               list_head[c] = {1'b0, idx};
            end
         end
         want.size_class = c[CLS_OUT_W-1:0];
         awaited_responses = {awaited_responses, want};
      endfunction

      function void compare_field(string field, logic [3:0] want, logic [3:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [CLS_OUT_W-1:0] cls,
                                   logic [IDX_W-1:0] granted);
         alloc_response_type want;
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with none awaited, status %0d class %0d block %0d",
                     $time, status, cls, granted);
            errors++;
         end else begin
            want = awaited_responses.pop_front();
            compare_field("status", 4'(want.status), 4'(status));
            compare_field("size_class", 4'(want.size_class), 4'(cls));
            compare_field("granted_block", 4'(want.granted_block), 4'(granted));
         end
      endfunction

      function int outstanding();
         return awaited_responses.size();
      endfunction

      // Returns a block of class c that is in use, searching from start, or start if none.
      function logic [IDX_W-1:0] pick_claimed(int c, logic [IDX_W-1:0] start);
         int k;
         int b;
         for (k = 0; k < BLOCKS_PER_CLASS; k++) begin
            b = (int'(start) + k) % BLOCKS_PER_CLASS;
            if (claimed[c * BLOCKS_PER_CLASS + b]) return IDX_W'(b);
         end
         return start;
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic                 req_func = FUNC_ALLOC;
   logic [SIZE_W-1:0]    req_request_size = '0;
   logic [IDX_W-1:0]     req_block_index = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [CLS_OUT_W-1:0] rsp_size_class;
   logic [IDX_W-1:0]     rsp_granted_block;

   free_list_scoreboard board;
   bit                  steady = 1'b0;
   bit                  hold_request = 1'b0;
   int                  idle_odds = 4;
   int                  stall_odds = 4;
   int                  hot [3];

   size_class_block_allocator_top #(
      .NUM_CLASSES      (NUM_CLASSES),
      .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_func          (req_func),
      .req_request_size  (req_request_size),
      .req_block_index   (req_block_index),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_size_class    (rsp_size_class),
      .rsp_granted_block (rsp_granted_block)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic pause_requests(int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offers one request, notes it at the edge where the block takes it, and sometimes then pauses.
   task automatic offer(logic f, logic [SIZE_W-1:0] size, logic [IDX_W-1:0] idx);
      req_push <= 1'b1;
      req_func <= f;
      req_request_size <= size;
      req_block_index <= idx;
      do @(posedge clock); while (req_full);
      board.note_request(f, size, idx);
      if (!steady && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         pause_requests($urandom_range(1, 7));
      end
   endtask

   task automatic wait_for_drain();
      req_push <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   function automatic logic [SIZE_W-1:0] size_in_class(int c);
      if (c == 0) return SIZE_W'($urandom_range(0, 2));
      return SIZE_W'($urandom_range((1 << c) + 1, 1 << (c + 1)));
   endfunction

   // Mostly requests on a few busy classes so that lists run dry and refill; frees
   // usually name a block that is really out, the rest are stray frees or oversize.
   task automatic random_request(int alloc_pct);
      int                c;
      logic              f;
      logic [IDX_W-1:0]  idx;
      if ($urandom_range(0, 99) < 4) begin
         offer(1'($urandom_range(0, 1)), SIZE_W'($urandom_range(65537, 131071)),
               IDX_W'($urandom));
      end else begin
         if ($urandom_range(0, 99) < 70) c = hot[$urandom_range(0, 2)];
         else c = $urandom_range(0, NUM_CLASSES - 1);
         f = ($urandom_range(0, 99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
         idx = IDX_W'($urandom);
         if (f == FUNC_FREE && $urandom_range(0, 9) < 8) idx = board.pick_claimed(c, idx);
         offer(f, size_in_class(c), idx);
      end
   endtask

   task automatic directed_requests();
      int k;
      offer(FUNC_ALLOC, 0, 15);
      offer(FUNC_ALLOC, 1, 0);
      offer(FUNC_ALLOC, 3, 0);
      offer(FUNC_ALLOC, 65536, 0);
      offer(FUNC_ALLOC, 65537, 0);
      offer(FUNC_FREE, 131071, 15);
      offer(FUNC_FREE, 2, 1);
      // The same block again is no longer in use.
      offer(FUNC_FREE, 1, 1);
      offer(FUNC_FREE, 0, 15);
      // Run the top class dry, then ask once more.
      for (k = 1; k < BLOCKS_PER_CLASS; k++) begin
         offer(FUNC_ALLOC, SIZE_W'(32769 + k * 2184), 0);
      end
      offer(FUNC_ALLOC, 40000, 0);
   endtask

   function automatic int pick_odds();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 3;
         default: return 10;
      endcase
   endfunction

   initial begin : stimulus
      int p;
      int k;
      int alloc_pct;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      directed_requests();
      for (p = 0; p < 6; p++) begin
         for (k = 0; k < 3; k++) hot[k] = $urandom_range(0, NUM_CLASSES - 1);
         alloc_pct = (p % 2 == 0) ? 75 : 30;
         idle_odds = pick_odds();
         stall_odds = pick_odds();
         if (p == 1) hold_request = 1'b1;
         for (k = 0; k < 150; k++) random_request(alloc_pct);
         if (p == 2) wait_for_drain();
      end
      steady = 1'b1;
      for (k = 0; k < 130; k++) random_request(50);
      wait_for_drain();
      repeat (10) @(posedge clock);
      if (board.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin : responses
      int  stall_left;
      int  hold_left;
      bit  pop_next;
      stall_left = 0;
      hold_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            board.check_response(rsp_status, rsp_size_class, rsp_granted_block);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop_next = 1'b0;
         end else if (!steady && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
            stall_left = $urandom_range(0, 6);
            pop_next = 1'b0;
         end else begin
            pop_next = 1'b1;
         end
         rsp_pop <= pop_next;
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
